### rtl/core/sticky_flow_to_consumer_mapper_core_macros.svh
// Assertion macros for the sticky flow-to-consumer mapper core.
// Included by the top level; no other dependencies.
`ifndef STICKY_FLOW_TO_CONSUMER_MAPPER_CORE_MACROS_SVH
`define STICKY_FLOW_TO_CONSUMER_MAPPER_CORE_MACROS_SVH

// Same-cycle implication.
`define SFCM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SFCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sfcm_pkg.sv
// Types and constants of the sticky flow-to-consumer mapper.
// No dependencies; used by sfcm_entry_eval and the top level.
package sfcm_pkg;

   localparam int MAX_GROUPS = 256;
   localparam int GROUP_AW   = 8;
   localparam int CONS_N     = 16;
   localparam int CONS_AW    = 4;
   localparam int KEY_W      = 64;
   localparam int TIME_W     = 63;
   localparam int CNT_W      = 9;
   localparam int CSR_AW     = 2;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_NO_CONS = 3'd1;
   localparam logic [2:0] STAT_FULL    = 3'd2;
   localparam logic [2:0] STAT_EXISTS  = 3'd3;
   localparam logic [2:0] STAT_ABSENT  = 3'd4;

   localparam logic [CSR_AW-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_LIMIT   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_REBAL   = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [KEY_W-1:0]   group_key;
      logic [CONS_AW-1:0] consumer_id;
      logic [TIME_W-1:0]  now;
   } req_type;

   typedef struct packed {
      logic [CONS_AW-1:0] assigned_consumer;
      logic [2:0]         status;
      logic               newly_mapped;
      logic               over_limit;
      logic [CNT_W-1:0]   group_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [CONS_AW-1:0] owner;
      logic [TIME_W-1:0]  seen;
   } entry_type;

   typedef enum logic [1:0] {
      PASS_MAIN   = 2'd0,
      PASS_REMOVE = 2'd1,
      PASS_PICK   = 2'd2,
      PASS_MOVE   = 2'd3
   } pass_kind_type;

   typedef struct packed {
      entry_type          ent;
      logic               vld;
      logic               pend;
      pass_kind_type      pass;
      logic [KEY_W-1:0]   req_key;
      logic [TIME_W-1:0]  now;
      logic [TIME_W-1:0]  tmo;
      logic [CONS_AW-1:0] owner_sel;
      logic               best_found;
      entry_type          best;
   } ev_in_type;

   typedef struct packed {
      logic drop;
      logic hit;
      logic free;
      logic better;
   } ev_out_type;

endpackage

### rtl/core/sfcm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sfcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/sfcm_entry_eval.sv
// Evaluates one group entry read during a table pass: expiry, hit, free slot,
// and whether it beats the current best candidate. Depends on sfcm_pkg.
module sfcm_entry_eval (
   input  sfcm_pkg::ev_in_type  ev_in,
   output sfcm_pkg::ev_out_type ev_out
);
   import sfcm_pkg::*;

   logic [TIME_W:0] expire_sum;
   logic            expired;
   logic            seen_lt, seen_eq, key_lt, owner_lt, owner_eq, owner_hit;
   logic            cand, less;

   always_comb begin
      expire_sum = {1'b0, ev_in.ent.seen} + {1'b0, ev_in.tmo};
      expired    = (ev_in.tmo != '0) && (expire_sum <= {1'b0, ev_in.now});
      seen_lt    = ev_in.ent.seen < ev_in.best.seen;
      seen_eq    = ev_in.ent.seen == ev_in.best.seen;
      key_lt     = ev_in.ent.key < ev_in.best.key;
      owner_lt   = ev_in.ent.owner < ev_in.best.owner;
      owner_eq   = ev_in.ent.owner == ev_in.best.owner;
      owner_hit  = ev_in.ent.owner == ev_in.owner_sel;

      ev_out.drop = 1'b0;
      ev_out.hit  = 1'b0;
      ev_out.free = 1'b0;
      cand        = 1'b0;
      less        = 1'b0;
      unique case (ev_in.pass)
         PASS_MAIN: begin
            ev_out.drop = ev_in.vld && expired;
            ev_out.hit  = ev_in.vld && !expired && (ev_in.ent.key == ev_in.req_key);
            ev_out.free = !ev_in.vld || expired;
            cand        = ev_in.vld && !expired;
            less        = seen_lt || (seen_eq && key_lt);
         end
         PASS_REMOVE: begin
            ev_out.drop = ev_in.vld && owner_hit;
         end
         PASS_PICK: begin
            cand = ev_in.vld && !ev_in.pend && owner_hit;
            less = key_lt;
         end
         PASS_MOVE: begin
            cand = ev_in.vld && ev_in.pend;
            less = owner_lt || (owner_eq && key_lt);
         end
         default: begin
         end
      endcase
      ev_out.better = cand && (!ev_in.best_found || less);
   end
endmodule

### rtl/core/sticky_flow_to_consumer_mapper_core.sv
// Top level of the sticky flow-to-consumer mapper: sequencer, consumer table
// and group memory. Depends on sfcm_pkg, sfcm_ram, sfcm_entry_eval and the macros header.
`include "sticky_flow_to_consumer_mapper_core_macros.svh"

// Maps group keys to consumer slots and keeps the mapping sticky. One
// transaction is taken while busy is low; its single result appears on
// rsp_item for exactly one cycle with rsp_strobe high and cannot be held off.
// Group entries live in one memory with a single read port, so every table
// pass reads all MAX_GROUPS entries in turn and holds the sequencer. Busy
// falls while the result is on the ports, so the next transaction can be
// taken at the edge at which the result is taken. A lookup miss with a
// consumer present adds the consumer sweep and the placement; removing an
// absent consumer and the unused mode go to the finish state with no pass.
// With rebalancing, each consumer is checked in turn, each group taken off
// an overloaded consumer costs one pass, and each group placed costs one
// pass, the consumer sweep and one write. Valid bits are flip-flops, so no
// clearing pass follows reset.
module sticky_flow_to_consumer_mapper_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  sfcm_pkg::req_type            req_item,
   output logic                         rsp_strobe,
   output sfcm_pkg::rsp_type            rsp_item,
   input  logic                         csr_we,
   input  logic [sfcm_pkg::CSR_AW-1:0]  csr_index,
   input  logic [sfcm_pkg::TIME_W-1:0]  csr_wdata
);
   import sfcm_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE    = 13'h0001,
      ST_SCAN    = 13'h0002,
      ST_LDECIDE = 13'h0004,
      ST_CSCAN   = 13'h0008,
      ST_LPLACE  = 13'h0010,
      ST_ADECIDE = 13'h0020,
      ST_RBCHECK = 13'h0040,
      ST_RBPICK  = 13'h0080,
      ST_RBADV   = 13'h0100,
      ST_RBMOVED = 13'h0200,
      ST_RBWRITE = 13'h0400,
      ST_REND    = 13'h0800,
      ST_FINISH  = 13'h1000
   } state_type;

   localparam int PROD_W = CONS_AW + 1 + CNT_W;

   // Control state.
   state_type            state_ff, state_in;
   pass_kind_type        pass_ff, pass_in;
   logic [TIME_W-1:0]    tmo_ff, tmo_in;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic                 rebal_ff, rebal_in;
   logic [GROUP_AW:0]    scan_cnt_ff, scan_cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [MAX_GROUPS-1:0] valid_ff, valid_in;
   logic [MAX_GROUPS-1:0] pend_ff, pend_in;
   logic [CONS_N-1:0]    cvalid_ff, cvalid_in;
   logic [CNT_W-1:0]     load_ff [CONS_N];
   logic [CNT_W-1:0]     load_in [CONS_N];
   logic [CNT_W-1:0]     total_ff, total_in;
   logic                 hit_found_ff, hit_found_in;
   logic                 free_found_ff, free_found_in;
   logic                 best_found_ff, best_found_in;
   logic                 slot_found_ff, slot_found_in;
   logic                 ll_found_ff, ll_found_in;
   logic                 cs_move_ff, cs_move_in;
   logic [CONS_AW-1:0]   cs_cnt_ff, cs_cnt_in;
   logic [CONS_AW-1:0]   cur_c_ff, cur_c_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;

   // Payload.
   req_type              req_ff, req_in;
   logic [GROUP_AW-1:0]  rd_idx_ff, rd_idx_in;
   logic [GROUP_AW-1:0]  hit_idx_ff, hit_idx_in;
   logic [CONS_AW-1:0]   hit_owner_ff, hit_owner_in;
   logic [GROUP_AW-1:0]  free_idx_ff, free_idx_in;
   logic [GROUP_AW-1:0]  best_idx_ff, best_idx_in;
   entry_type            best_ent_ff, best_ent_in;
   logic [GROUP_AW-1:0]  slot_idx_ff, slot_idx_in;
   logic [CONS_AW-1:0]   ll_id_ff, ll_id_in;
   logic [CNT_W-1:0]     ll_load_ff, ll_load_in;
   logic [2:0]           status_ff, status_in;
   logic [CONS_AW-1:0]   assigned_ff, assigned_in;
   logic                 fresh_ff, fresh_in;
   rsp_type              rsp_ff, rsp_in;

   // Memory port and evaluator.
   logic                 ram_we;
   logic [GROUP_AW-1:0]  ram_waddr, ram_raddr;
   entry_type            ram_wdata, ram_rdata;
   ev_in_type            ev_in;
   ev_out_type           ev_out;

   // Combinational helpers.
   logic                 begin_scan, begin_cscan, cscan_move;
   pass_kind_type        scan_kind;
   logic                 drop_en;
   logic [GROUP_AW-1:0]  drop_idx;
   logic [CONS_AW-1:0]   drop_owner;
   logic [CONS_AW:0]     n_cons;
   logic [CNT_W-1:0]     cur_load;
   logic [PROD_W-1:0]    share_prod;
   logic                 over_target, evict;

   sfcm_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_GROUPS)
   ) u_group_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sfcm_entry_eval u_eval (
      .ev_in  (ev_in),
      .ev_out (ev_out)
   );

   always_comb begin
      ev_in.ent        = ram_rdata;
      ev_in.vld        = valid_ff[rd_idx_ff];
      ev_in.pend       = pend_ff[rd_idx_ff];
      ev_in.pass       = pass_ff;
      ev_in.req_key    = req_ff.group_key;
      ev_in.now        = req_ff.now;
      ev_in.tmo        = tmo_ff;
      ev_in.owner_sel  = (pass_ff == PASS_PICK) ? cur_c_ff : req_ff.consumer_id;
      ev_in.best_found = best_found_ff;
      ev_in.best       = best_ent_ff;
   end

   // A consumer is over its share when load > ceil(total / n), which is
   // the same as total <= n * (load - 1) for a nonzero load.
   always_comb begin
      n_cons = '0;
      for (int i = 0; i < CONS_N; i++) begin
         n_cons = n_cons + (CONS_AW + 1)'(cvalid_ff[i]);
      end
      cur_load    = load_ff[cur_c_ff];
      share_prod  = PROD_W'(n_cons) * PROD_W'(cur_load - CNT_W'(1));
      over_target = cvalid_ff[cur_c_ff] && (cur_load != '0) &&
                    (PROD_W'(total_ff) <= share_prod);
      evict = rebal_ff && (limit_ff != '0) &&
              ({1'b0, total_ff} + (CNT_W + 1)'(1) > {1'b0, limit_ff}) && best_found_ff;
   end

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      tmo_in        = tmo_ff;
      limit_in      = limit_ff;
      rebal_in      = rebal_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_vld_in     = 1'b0;
      valid_in      = valid_ff;
      pend_in       = pend_ff;
      cvalid_in     = cvalid_ff;
      load_in       = load_ff;
      total_in      = total_ff;
      hit_found_in  = hit_found_ff;
      free_found_in = free_found_ff;
      best_found_in = best_found_ff;
      slot_found_in = slot_found_ff;
      ll_found_in   = ll_found_ff;
      cs_move_in    = cs_move_ff;
      cs_cnt_in     = cs_cnt_ff;
      cur_c_in      = cur_c_ff;
      rsp_strobe_in = 1'b0;
      req_in        = req_ff;
      rd_idx_in     = rd_idx_ff;
      hit_idx_in    = hit_idx_ff;
      hit_owner_in  = hit_owner_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_ent_in   = best_ent_ff;
      slot_idx_in   = slot_idx_ff;
      ll_id_in      = ll_id_ff;
      ll_load_in    = ll_load_ff;
      status_in     = status_ff;
      assigned_in   = assigned_ff;
      fresh_in      = fresh_ff;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = scan_cnt_ff[GROUP_AW-1:0];
      begin_scan    = 1'b0;
      scan_kind     = PASS_MAIN;
      begin_cscan   = 1'b0;
      cscan_move    = 1'b0;
      drop_en       = 1'b0;
      drop_idx      = rd_idx_ff;
      drop_owner    = ram_rdata.owner;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT: tmo_in   = csr_wdata;
            CSR_LIMIT:   limit_in = csr_wdata[CNT_W-1:0];
            CSR_REBAL:   rebal_in = csr_wdata[0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_item;
               status_in   = STAT_OK;
               assigned_in = '0;
               fresh_in    = 1'b0;
               unique case (req_item.mode) inside
                  MODE_LOOKUP, MODE_ADD: begin
                     begin_scan = 1'b1;
                     scan_kind  = PASS_MAIN;
                  end
                  MODE_REMOVE: begin
                     if (!cvalid_ff[req_item.consumer_id]) begin
                        status_in = STAT_ABSENT;
                        state_in  = ST_FINISH;
                     end else begin
                        begin_scan = 1'b1;
                        scan_kind  = PASS_REMOVE;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end

         ST_SCAN: begin
            rd_vld_in   = !scan_cnt_ff[GROUP_AW];
            rd_idx_in   = scan_cnt_ff[GROUP_AW-1:0];
            scan_cnt_in = scan_cnt_ff + (GROUP_AW + 1)'(!scan_cnt_ff[GROUP_AW]);
            if (rd_vld_ff) begin
               drop_en = ev_out.drop;
               if (ev_out.hit && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_owner_in = ram_rdata.owner;
               end
               if (ev_out.free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (ev_out.better) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_ent_in   = ram_rdata;
               end
            end else if (scan_cnt_ff[GROUP_AW]) begin
               unique case (pass_ff)
                  PASS_MAIN: state_in = (req_ff.mode == MODE_LOOKUP) ? ST_LDECIDE
                                                                     : ST_ADECIDE;
                  PASS_REMOVE: state_in = ST_REND;
                  PASS_PICK:   state_in = ST_RBPICK;
                  PASS_MOVE:   state_in = ST_RBMOVED;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end

         ST_LDECIDE: begin
            if (hit_found_ff) begin
               ram_we      = 1'b1;
               ram_waddr   = hit_idx_ff;
               ram_wdata   = '{key: req_ff.group_key, owner: hit_owner_ff, seen: req_ff.now};
               assigned_in = hit_owner_ff;
               state_in    = ST_FINISH;
            end else if (cvalid_ff == '0) begin
               status_in = STAT_NO_CONS;
               state_in  = ST_FINISH;
            end else begin
               if (evict) begin
                  drop_en    = 1'b1;
                  drop_idx   = best_idx_ff;
                  drop_owner = best_ent_ff.owner;
               end
               // An evicted entry below the first free slot becomes the slot.
               if (free_found_ff && !(evict && (best_idx_ff < free_idx_ff))) begin
                  slot_found_in = 1'b1;
                  slot_idx_in   = free_idx_ff;
               end else if (evict) begin
                  slot_found_in = 1'b1;
                  slot_idx_in   = best_idx_ff;
               end else begin
                  slot_found_in = 1'b0;
               end
               begin_cscan = 1'b1;
               cscan_move  = 1'b0;
            end
         end

         ST_CSCAN: begin
            if (cvalid_ff[cs_cnt_ff] && (!ll_found_ff || (load_ff[cs_cnt_ff] < ll_load_ff)))
            begin
               ll_found_in = 1'b1;
               ll_id_in    = cs_cnt_ff;
               ll_load_in  = load_ff[cs_cnt_ff];
            end
            if (cs_cnt_ff == CONS_AW'(CONS_N - 1)) begin
               state_in = cs_move_ff ? ST_RBWRITE : ST_LPLACE;
            end else begin
               cs_cnt_in = cs_cnt_ff + CONS_AW'(1);
            end
         end

         ST_LPLACE: begin
            if (!slot_found_ff) begin
               status_in = STAT_FULL;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = slot_idx_ff;
               ram_wdata = '{key: req_ff.group_key, owner: ll_id_ff, seen: req_ff.now};
               valid_in[slot_idx_ff] = 1'b1;
               pend_in[slot_idx_ff]  = 1'b0;
               load_in[ll_id_ff]     = load_ff[ll_id_ff] + CNT_W'(1);
               total_in              = total_ff + CNT_W'(1);
               assigned_in           = ll_id_ff;
               fresh_in              = 1'b1;
            end
            state_in = ST_FINISH;
         end

         ST_ADECIDE: begin
            if (cvalid_ff[req_ff.consumer_id]) begin
               status_in = STAT_EXISTS;
               state_in  = ST_FINISH;
            end else begin
               cvalid_in[req_ff.consumer_id] = 1'b1;
               load_in[req_ff.consumer_id]   = '0;
               cur_c_in = '0;
               state_in = rebal_ff ? ST_RBCHECK : ST_FINISH;
            end
         end

         ST_RBCHECK: begin
            if (over_target) begin
               begin_scan = 1'b1;
               scan_kind  = PASS_PICK;
            end else begin
               state_in = ST_RBADV;
            end
         end

         ST_RBPICK: begin
            if (best_found_ff) begin
               pend_in[best_idx_ff] = 1'b1;
               load_in[cur_c_ff]    = cur_load - CNT_W'(1);
               state_in             = ST_RBCHECK;
            end else begin
               state_in = ST_RBADV;
            end
         end

         ST_RBADV: begin
            if (cur_c_ff == CONS_AW'(CONS_N - 1)) begin
               begin_scan = 1'b1;
               scan_kind  = PASS_MOVE;
            end else begin
               cur_c_in = cur_c_ff + CONS_AW'(1);
               state_in = ST_RBCHECK;
            end
         end

         ST_RBMOVED: begin
            if (!best_found_ff) begin
               state_in = ST_FINISH;
            end else begin
               begin_cscan = 1'b1;
               cscan_move  = 1'b1;
            end
         end

         ST_RBWRITE: begin
            // The moved group keeps its last-seen time.
            ram_we    = 1'b1;
            ram_waddr = best_idx_ff;
            ram_wdata = '{key: best_ent_ff.key, owner: ll_id_ff, seen: best_ent_ff.seen};
            pend_in[best_idx_ff] = 1'b0;
            load_in[ll_id_ff]    = load_ff[ll_id_ff] + CNT_W'(1);
            begin_scan = 1'b1;
            scan_kind  = PASS_MOVE;
         end

         ST_REND: begin
            cvalid_in[req_ff.consumer_id] = 1'b0;
            load_in[req_ff.consumer_id]   = '0;
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            rsp_in.assigned_consumer = assigned_ff;
            rsp_in.status            = status_ff;
            rsp_in.newly_mapped      = fresh_ff;
            rsp_in.over_limit        = (limit_ff != '0) && (total_ff > limit_ff);
            rsp_in.group_count       = total_ff;
            rsp_strobe_in            = 1'b1;
            state_in                 = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      if (drop_en) begin
         valid_in[drop_idx] = 1'b0;
         pend_in[drop_idx]  = 1'b0;
         if (load_ff[drop_owner] != '0) begin
            load_in[drop_owner] = load_ff[drop_owner] - CNT_W'(1);
         end
         if (total_ff != '0) begin
            total_in = total_ff - CNT_W'(1);
         end
      end

      if (begin_scan) begin
         state_in      = ST_SCAN;
         pass_in       = scan_kind;
         scan_cnt_in   = '0;
         rd_vld_in     = 1'b0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         best_found_in = 1'b0;
      end

      if (begin_cscan) begin
         state_in    = ST_CSCAN;
         cs_cnt_in   = '0;
         ll_found_in = 1'b0;
         cs_move_in  = cscan_move;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pass_ff       <= PASS_MAIN;
         tmo_ff        <= '0;
         limit_ff      <= '0;
         rebal_ff      <= 1'b0;
         scan_cnt_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         pend_ff       <= '0;
         cvalid_ff     <= '0;
         for (int i = 0; i < CONS_N; i++) begin
            load_ff[i] <= '0;
         end
         total_ff      <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         slot_found_ff <= 1'b0;
         ll_found_ff   <= 1'b0;
         cs_move_ff    <= 1'b0;
         cs_cnt_ff     <= '0;
         cur_c_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         tmo_ff        <= tmo_in;
         limit_ff      <= limit_in;
         rebal_ff      <= rebal_in;
         scan_cnt_ff   <= scan_cnt_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         pend_ff       <= pend_in;
         cvalid_ff     <= cvalid_in;
         load_ff       <= load_in;
         total_ff      <= total_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         best_found_ff <= best_found_in;
         slot_found_ff <= slot_found_in;
         ll_found_ff   <= ll_found_in;
         cs_move_ff    <= cs_move_in;
         cs_cnt_ff     <= cs_cnt_in;
         cur_c_ff      <= cur_c_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_owner_ff <= hit_owner_in;
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ent_ff  <= best_ent_in;
      slot_idx_ff  <= slot_idx_in;
      ll_id_ff     <= ll_id_in;
      ll_load_ff   <= ll_load_in;
      status_ff    <= status_in;
      assigned_ff  <= assigned_in;
      fresh_ff     <= fresh_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `SFCM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted transaction did not raise busy")
   `SFCM_ASSERT_IMPLIES(a_strobe_after_finish, clock, reset, rsp_strobe, $past(state_ff == ST_FINISH), "result strobe without a finished transaction")
   `SFCM_ASSERT_IMPLIES(a_no_write_in_scan, clock, reset, ram_we, state_ff != ST_SCAN, "group memory written during a table pass")
   `SFCM_ASSERT_IMPLIES(a_total_range, clock, reset, 1'b1, total_ff <= CNT_W'(MAX_GROUPS), "group count above table capacity")
endmodule
